FILE: rtl/core/snfgl_pkg.sv
// Shared constants, types and state encodings for the group list unit.
`default_nettype none
package snfgl_pkg;

    localparam int MAX_EXPERTS_DEF = 64;
    localparam int GC_W            = 32;
    localparam int IDX_W           = 6;
    localparam int CNT_W           = 31;
    localparam int NUM_W           = 7;
    localparam logic [NUM_W-1:0] NUM_EXPERTS_RST = 7'd64;
    localparam int QUEUE_DEPTH     = 2;

    typedef struct packed {
        logic             positive;
        logic             ends_list;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] cnt;
    } cmd_t;

    typedef enum logic [1:0] {
        B_TAKE,
        B_READ,
        B_EMIT
    } back_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/snfgl_if.sv
// Channel interfaces: count input, pair output and configuration write.
`default_nettype none
interface snfgl_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [snfgl_pkg::GC_W-1:0]    group_count;

    modport source (output valid, output group_count, input ready);
    modport sink (input valid, input group_count, output ready);
endinterface

interface snfgl_out_if;
    logic                          valid;
    logic                          ready;
    logic [snfgl_pkg::IDX_W-1:0]   expert_index;
    logic [snfgl_pkg::CNT_W-1:0]   pair_count;
    logic                          last_pair;

    modport source (output valid, output expert_index, output pair_count,
                    output last_pair, input ready);
    modport sink (input valid, input expert_index, input pair_count,
                  input last_pair, output ready);
endinterface

interface snfgl_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [snfgl_pkg::NUM_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/snfgl_front.sv
// Front end: accepts counts, tracks the expert position and classifies each count.
`default_nettype none
module snfgl_front #(
    parameter int MAX_EXPERTS = snfgl_pkg::MAX_EXPERTS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    snfgl_in_if.sink             counts,
    snfgl_cfg_if.sink            cfg,
    output logic                 push_valid,
    input  wire logic            push_ready,
    output snfgl_pkg::cmd_t      push_data
);

    localparam int TW = $clog2(MAX_EXPERTS + 1);
    localparam int LW = snfgl_pkg::NUM_W + 1;

    logic [snfgl_pkg::NUM_W-1:0] num_experts_reg;
    logic [TW-1:0]               next_expert_reg;
    logic [TW-1:0]               next_expert_next;
    logic [snfgl_pkg::NUM_W-1:0] list_len;
    logic                        ends_list;
    logic                        accept;

    assign cfg.ready    = 1'b1;
    assign counts.ready = push_ready;
    assign push_valid   = counts.valid;
    assign accept       = counts.valid && push_ready;

    always_comb
    begin
        if (num_experts_reg == '0)
            list_len = snfgl_pkg::NUM_W'(1);
        else if (num_experts_reg > snfgl_pkg::NUM_W'(MAX_EXPERTS))
            list_len = snfgl_pkg::NUM_W'(MAX_EXPERTS);
        else
            list_len = num_experts_reg;
    end

    assign ends_list = (LW'(next_expert_reg) + LW'(1)) >= LW'(list_len);

    always_comb
    begin
        push_data.positive  = (counts.group_count != '0) &&
                              !counts.group_count[snfgl_pkg::GC_W-1];
        push_data.ends_list = ends_list;
        push_data.idx       = snfgl_pkg::IDX_W'(next_expert_reg);
        push_data.cnt       = counts.group_count[snfgl_pkg::CNT_W-1:0];
        next_expert_next    = ends_list ? '0 : next_expert_reg + TW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_experts_reg <= snfgl_pkg::NUM_EXPERTS_RST;
            next_expert_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
                num_experts_reg <= cfg.data;
            if (accept)
                next_expert_reg <= next_expert_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/snfgl_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none
module snfgl_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire snfgl_pkg::cmd_t push_data,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output snfgl_pkg::cmd_t      pop_data
);

    localparam int DEPTH = snfgl_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    snfgl_pkg::cmd_t slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   fill_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = fill_reg != CW'(DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            if (do_push && !do_pop)
                fill_reg <= fill_reg + CW'(1);
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - CW'(1);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/snfgl_back.sv
// Back end: emits nonempty pairs, stores empty experts and flushes them at list end.
`default_nettype none
module snfgl_back #(
    parameter int MAX_EXPERTS = snfgl_pkg::MAX_EXPERTS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    input  wire snfgl_pkg::cmd_t pop_data,
    snfgl_out_if.source          pairs
);

    localparam int AW = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1;
    localparam int TW = $clog2(MAX_EXPERTS + 1);

    logic [snfgl_pkg::IDX_W-1:0] empty_mem [MAX_EXPERTS];
    logic [snfgl_pkg::IDX_W-1:0] rd_data_reg;

    snfgl_pkg::back_state_t      state_reg;
    snfgl_pkg::back_state_t      state_next;
    logic [TW-1:0]               total_reg;
    logic [TW-1:0]               total_next;
    logic [TW-1:0]               rd_ptr_reg;
    logic [TW-1:0]               rd_ptr_next;

    logic                        out_valid_reg;
    logic [snfgl_pkg::IDX_W-1:0] out_idx_reg;
    logic [snfgl_pkg::CNT_W-1:0] out_cnt_reg;
    logic                        out_last_reg;

    logic                        slot_free;
    logic                        load;
    logic [snfgl_pkg::IDX_W-1:0] load_idx;
    logic [snfgl_pkg::CNT_W-1:0] load_cnt;
    logic                        load_last;
    logic                        mem_we;
    logic                        flush_last;

    assign pairs.valid        = out_valid_reg;
    assign pairs.expert_index = out_idx_reg;
    assign pairs.pair_count   = out_cnt_reg;
    assign pairs.last_pair    = out_last_reg;

    assign slot_free  = !out_valid_reg || pairs.ready;
    assign flush_last = (rd_ptr_reg + TW'(1)) == total_reg;

    always_comb
    begin
        state_next  = state_reg;
        total_next  = total_reg;
        rd_ptr_next = rd_ptr_reg;
        pop_ready   = 1'b0;
        load        = 1'b0;
        load_idx    = pop_data.idx;
        load_cnt    = pop_data.cnt;
        load_last   = 1'b0;
        mem_we      = 1'b0;
        case (state_reg)
            snfgl_pkg::B_TAKE:
            begin
                pop_ready = slot_free;
                if (pop_valid && slot_free)
                begin
                    if (pop_data.positive)
                    begin
                        load      = 1'b1;
                        load_last = pop_data.ends_list && (total_reg == '0);
                        if (pop_data.ends_list && (total_reg != '0))
                        begin
                            rd_ptr_next = '0;
                            state_next  = snfgl_pkg::B_READ;
                        end
                    end
                    else
                    begin
                        if (total_reg < TW'(MAX_EXPERTS))
                        begin
                            mem_we     = 1'b1;
                            total_next = total_reg + TW'(1);
                        end
                        if (pop_data.ends_list)
                        begin
                            rd_ptr_next = '0;
                            state_next  = snfgl_pkg::B_READ;
                        end
                    end
                end
            end
            snfgl_pkg::B_READ:
            begin
                state_next = snfgl_pkg::B_EMIT;
            end
            snfgl_pkg::B_EMIT:
            begin
                load_idx = rd_data_reg;
                load_cnt = '0;
                if (slot_free)
                begin
                    load        = 1'b1;
                    load_last   = flush_last;
                    rd_ptr_next = rd_ptr_reg + TW'(1);
                    if (flush_last)
                    begin
                        total_next = '0;
                        state_next = snfgl_pkg::B_TAKE;
                    end
                    else
                    begin
                        state_next = snfgl_pkg::B_READ;
                    end
                end
            end
            default:
            begin
                state_next = snfgl_pkg::B_TAKE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            empty_mem[total_reg[AW-1:0]] <= pop_data.idx;
        rd_data_reg <= empty_mem[rd_ptr_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_idx_reg  <= load_idx;
            out_cnt_reg  <= load_cnt;
            out_last_reg <= load_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= snfgl_pkg::B_TAKE;
            total_reg     <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            rd_ptr_reg <= rd_ptr_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (pairs.ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/stable_nonempty_first_group_list_unit.sv
// Top level of the stable nonempty-first group list unit.
//
// counts: one signed group count per expert, in expert order. Each transfer
//   advances the expert position; the count that reaches the configured
//   length ends the list and the position returns to zero.
// pairs: (expert_index, pair_count, last_pair). A positive count yields its
//   pair via the command queue and output register when the back end is
//   free. Empty experts are stored and, after the list's final count, read
//   out in ascending order with count 0, through a read and an emit state per
//   stored expert; the final pair of the list carries last_pair.
// cfg: writes num_experts (0 acts as 1, values above MAX_EXPERTS are capped);
//   write only while the unit is idle.
// Throughput: one count per cycle while the two-entry command queue has room;
//   the flush of a list's stored empty experts holds the back end in its read
//   and emit states, during which counts fill the queue and then stall.
// A stalled pairs receiver holds the output register; the back end and then
//   the queue stop, and counts.ready drops when the queue is full.
// Reset clears position, empty total, queue and output valid; num_experts
//   returns to 64. The empty-expert store needs no clearing pass.
`default_nettype none
module stable_nonempty_first_group_list_unit #(
    parameter int MAX_EXPERTS = snfgl_pkg::MAX_EXPERTS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    snfgl_in_if.sink    counts,
    snfgl_cfg_if.sink   cfg,
    snfgl_out_if.source pairs
);

    logic            push_valid;
    logic            push_ready;
    snfgl_pkg::cmd_t push_data;
    logic            pop_valid;
    logic            pop_ready;
    snfgl_pkg::cmd_t pop_data;

    snfgl_front #(
        .MAX_EXPERTS (MAX_EXPERTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .counts     (counts),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    snfgl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    snfgl_back #(
        .MAX_EXPERTS (MAX_EXPERTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .pairs     (pairs)
    );

endmodule
`default_nettype wire

FILE: test/tb_stable_nonempty_first_group_list_unit.sv
// Testbench for the nonempty-first group list unit: directed and random lists, predicted pairs.
`default_nettype none
module tb_stable_nonempty_first_group_list_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import snfgl_pkg::*;

    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 100;

    typedef struct packed {
        logic [IDX_W-1:0] expert_index;
        logic [CNT_W-1:0] pair_count;
        logic             last_pair;
    } pair_t;

    logic clk;
    logic rst_n;

    snfgl_in_if  counts_if ();
    snfgl_cfg_if cfg_if ();
    snfgl_out_if pairs_if ();

    stable_nonempty_first_group_list_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .counts(counts_if),
        .cfg   (cfg_if),
        .pairs (pairs_if)
    );

    pair_t            expected_pairs[$];
    logic [NUM_W-1:0] num_experts_cfg = NUM_EXPERTS_RST;
    logic [NUM_W-1:0] next_pos = '0;
    logic [IDX_W-1:0] empty_idx[MAX_EXPERTS_DEF];
    int               empty_total = 0;
    int               errors = 0;
    int               tx_idle_pct = 0;
    int               rx_stall_pct = 0;
    int               cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("stable_nonempty_first_group_list_unit test failed");
        $finish;
    end

    function automatic int effective_length(input logic [NUM_W-1:0] n);
        int len;
        len = int'(n);
        if (len == 0)
            len = 1;
        if (len > MAX_EXPERTS_DEF)
            len = MAX_EXPERTS_DEF;
        return len;
    endfunction

    function automatic void predict_count(input logic [GC_W-1:0] raw);
        pair_t p;
        logic  ends;
        ends = (int'(next_pos) + 1) >= effective_length(num_experts_cfg);
        if (raw != '0 && !raw[GC_W-1])
        begin
            p.expert_index = next_pos[IDX_W-1:0];
            p.pair_count   = raw[CNT_W-1:0];
            p.last_pair    = ends && (empty_total == 0);
            expected_pairs.push_back(p);
        end
        else if (empty_total < MAX_EXPERTS_DEF)
        begin
            empty_idx[empty_total] = next_pos[IDX_W-1:0];
            empty_total++;
        end
        if (!ends)
            next_pos++;
        else
        begin
            for (int i = 0; i < empty_total; i++)
            begin
                p.expert_index = empty_idx[i];
                p.pair_count   = '0;
                p.last_pair    = (i + 1 == empty_total);
                expected_pairs.push_back(p);
            end
            next_pos    = '0;
            empty_total = 0;
        end
    endfunction

    always @(posedge clk)
    begin
        pairs_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin : track
        pair_t want;
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
                num_experts_cfg = cfg_if.data;
            if (counts_if.valid && counts_if.ready)
                predict_count(counts_if.group_count);
            if (pairs_if.valid && pairs_if.ready)
            begin
                if (expected_pairs.size() == 0)
                begin
                    $display("%0t: unexpected pair: expected none, ", $time,
                             "got idx %0d count %0d last %0b",
                             pairs_if.expert_index, pairs_if.pair_count,
                             pairs_if.last_pair);
                    errors++;
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (pairs_if.expert_index !== want.expert_index
                        || pairs_if.pair_count !== want.pair_count
                        || pairs_if.last_pair !== want.last_pair)
                    begin
                        $display("%0t: pair mismatch: ", $time,
                                 "expected idx %0d count %0d last %0b, ",
                                 want.expert_index, want.pair_count, want.last_pair,
                                 "got idx %0d count %0d last %0b",
                                 pairs_if.expert_index, pairs_if.pair_count,
                                 pairs_if.last_pair);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic send_count(input logic [GC_W-1:0] gc);
        counts_if.valid       <= 1'b1;
        counts_if.group_count <= gc;
        do @(posedge clk); while (!counts_if.ready);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            counts_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    // drop valid and let the pipeline empty out
    task automatic wait_idle();
        counts_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_num_experts(input logic [NUM_W-1:0] n);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= n;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [GC_W-1:0] random_count();
        case ($urandom_range(5))
            0: return '0;
            1: return $urandom;
            2: return GC_W'($urandom_range(1, 1000));
            3: return {1'b1, 31'($urandom)};
            4:
            begin
                case ($urandom_range(3))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0001;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return {1'b0, 31'($urandom)};
        endcase
    endfunction

    // reset length of 64 holds the list open; a shorter length mid-list ends it
    task automatic test_partial_list_resize();
        send_count(32'h7fff_ffff);
        send_count(32'h8000_0000);
        send_count(32'h0000_0000);
        send_count(32'h0000_0001);
        send_count(32'hffff_ffff);
        write_num_experts(7'd3);
        send_count(32'h0000_0002);
    endtask

    task automatic test_single_expert_lists();
        write_num_experts(7'd0);
        send_count(32'd5);
        send_count(32'd0);
        send_count(-32'sd7);
        write_num_experts(7'd1);
        send_count(32'h4000_0000);
    endtask

    task automatic test_all_positive();
        write_num_experts(7'd3);
        send_count(32'd1);
        send_count(32'h7fff_ffff);
        send_count(32'd12345);
    endtask

    task automatic test_all_empty();
        write_num_experts(7'd4);
        send_count(32'd0);
        send_count(32'hffff_ffff);
        send_count(32'h8000_0000);
        send_count(32'd0);
    endtask

    task automatic test_random_lists();
        int               tx_pct[4] = '{0, 85, 0, 12};
        int               rx_pct[4] = '{0, 0, 85, 12};
        logic [NUM_W-1:0] opening[4] = '{7'd127, 7'd64, 7'd65, 7'd1};
        logic [NUM_W-1:0] n;
        int               sent;
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            tx_idle_pct  = tx_pct[ph];
            rx_stall_pct = rx_pct[ph];
            sent = 0;
            n = opening[ph];
            while (sent < PHASE_ITEMS)
            begin
                write_num_experts(n);
                for (int k = 0; k < effective_length(n); k++)
                    send_count(random_count());
                sent += effective_length(n);
                if ($urandom_range(99) < 80)
                    n = NUM_W'($urandom_range(1, 8));
                else
                    n = NUM_W'($urandom_range(127));
            end
        end
    endtask

    initial
    begin
        rst_n                 <= 1'b0;
        counts_if.valid       <= 1'b0;
        counts_if.group_count <= '0;
        cfg_if.valid          <= 1'b0;
        cfg_if.data           <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_partial_list_resize();
        test_single_expert_lists();
        test_all_positive();
        test_all_empty();
        test_random_lists();
        wait_idle();

        if (errors == 0)
            $display("stable_nonempty_first_group_list_unit test passed");
        else
            $display("stable_nonempty_first_group_list_unit test failed");
        $finish;
    end
endmodule
`default_nettype wire
